// ===== hdl/htb_pkg.sv =====
// Shared types and constants for the hex text to byte parser.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package htb_pkg;

  // Result codes carried on the result channel
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_t;

  // Parser phase; the fourth code is never entered and acts as between bytes
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  localparam int FIELD_W = 16;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT   = 8'h20;

endpackage

`default_nettype wire

// ===== hdl/htb_if.sv =====
// Valid/ready channel interfaces for the hex text parser: character input
// and result output. Depends on htb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface htb_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink (input valid, input text_char, output ready);
endinterface

interface htb_result_if;
  logic                         valid;
  logic                         ready;
  htb_pkg::result_kind_t        result_kind;
  logic [7:0]                   data_byte;
  logic [htb_pkg::FIELD_W-1:0]  byte_count;
  logic [htb_pkg::FIELD_W-1:0]  error_position;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_count, output error_position, input ready);
  modport sink (input valid, input result_kind, input data_byte,
                input byte_count, input error_position, output ready);
endinterface

`default_nettype wire

// ===== hdl/hex_text_to_bytes.sv =====
// Hex text parser: turns a stream of ASCII hex characters into bytes.
// Depends on htb_pkg and the channel interfaces in htb_if.sv.
//
// Usage:
//   chars carries one character per beat; a zero character ends a text.
//   results carries at most one result per character: a parsed byte, a
//   success report with the byte count, or an error with the offset of
//   the offending character. After an error the rest of the text up to
//   its terminator is dropped without results.
// Timing:
//   A result is registered and available in the cycle after its character is accepted.
//   One character per cycle is accepted unless stalled; the parse state
//   updates on acceptance, and one result register sits on the output.
// Stalls:
//   chars.ready is high while the result register is empty or being taken
//   in the same cycle. A held result stops input only if the receiver
//   keeps results.ready low.
// Reset:
//   rst (synchronous) empties the result register and starts a new text
//   with zeroed counters.
`timescale 1ns / 1ps
`default_nettype none

module hex_text_to_bytes #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst,
  htb_char_if.sink         chars,
  htb_result_if.source     results
);
  import htb_pkg::*;

  phase_t                 phase, phase_next;
  logic [3:0]             high_nibble, high_nibble_next;
  logic [COUNT_WIDTH-1:0] parsed_count, parsed_count_next;
  logic [COUNT_WIDTH-1:0] char_offset, char_offset_next;

  logic                   out_valid;
  result_kind_t           out_kind;
  logic [7:0]             out_byte;
  logic [FIELD_W-1:0]     out_count;
  logic [FIELD_W-1:0]     out_pos;

  logic                   accept;
  logic [7:0]             c;
  logic [7:0]             lower;
  logic                   is_num, is_alpha, is_digit, is_sep;
  logic [3:0]             nib;

  logic                   has_result;
  result_kind_t           res_kind;
  logic [7:0]             res_byte;
  logic [FIELD_W-1:0]     res_count;
  logic [FIELD_W-1:0]     res_pos;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(logic [COUNT_WIDTH-1:0] v);
    return ((v >> FIELD_W) != '0) ? FIELD_MAX : FIELD_W'(v);
  endfunction

  assign accept       = chars.valid && chars.ready;
  assign chars.ready  = !out_valid || results.ready;
  assign c            = chars.text_char;
  assign lower        = c | CASE_BIT;

  // Classify the character
  assign is_num   = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = (lower >= 8'h61) && (lower <= 8'h66);
  assign is_digit = is_num || is_alpha;
  assign is_sep   = (c == CHAR_SPACE) || (c == CHAR_TAB) ||
                    (c == CHAR_CR) || (c == CHAR_LF);
  // a-f: low nibble of 0x61..0x66 plus 9 gives 10..15
  assign nib      = is_num ? c[3:0] : (lower[3:0] + 4'd9);

  // Next state
  always_comb begin
    phase_next        = phase;
    high_nibble_next  = high_nibble;
    parsed_count_next = parsed_count;
    char_offset_next  = char_offset;
    case (phase)
      PH_DROP: begin
        if (c == CHAR_NUL) begin
          phase_next        = PH_IDLE;
          high_nibble_next  = '0;
          parsed_count_next = '0;
          char_offset_next  = '0;
        end else begin
          char_offset_next = sat_inc(char_offset);
        end
      end
      default: begin
        if (c == CHAR_NUL) begin
          phase_next        = PH_IDLE;
          high_nibble_next  = '0;
          parsed_count_next = '0;
          char_offset_next  = '0;
        end else begin
          char_offset_next = sat_inc(char_offset);
          if (is_digit) begin
            if (phase == PH_HIGH) begin
              phase_next        = PH_IDLE;
              high_nibble_next  = '0;
              parsed_count_next = sat_inc(parsed_count);
            end else begin
              phase_next       = PH_HIGH;
              high_nibble_next = nib;
            end
          end else if (is_sep && phase != PH_HIGH) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next       = PH_DROP;
            high_nibble_next = '0;
          end
        end
      end
    endcase
  end

  // Result for the current character
  always_comb begin
    has_result = 1'b0;
    res_kind   = KIND_BYTE;
    res_byte   = '0;
    res_count  = '0;
    res_pos    = '0;
    case (phase)
      PH_DROP: has_result = 1'b0;
      default: begin
        if (c == CHAR_NUL) begin
          has_result = 1'b1;
          if (phase == PH_HIGH) begin
            res_kind = KIND_ERROR;
            res_pos  = to_field(char_offset);
          end else begin
            res_kind  = KIND_DONE;
            res_count = to_field(parsed_count);
          end
        end else if (is_digit) begin
          if (phase == PH_HIGH) begin
            has_result = 1'b1;
            res_kind   = KIND_BYTE;
            res_byte   = {high_nibble, nib};
          end
        end else if (!(is_sep && phase != PH_HIGH)) begin
          has_result = 1'b1;
          res_kind   = KIND_ERROR;
          res_pos    = to_field(char_offset);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      high_nibble  <= '0;
      parsed_count <= '0;
      char_offset  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        high_nibble  <= high_nibble_next;
        parsed_count <= parsed_count_next;
        char_offset  <= char_offset_next;
        out_valid    <= has_result;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload register: load with each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind  <= res_kind;
      out_byte  <= res_byte;
      out_count <= res_count;
      out_pos   <= res_pos;
    end
  end

  assign results.valid          = out_valid;
  assign results.result_kind    = out_kind;
  assign results.data_byte      = out_byte;
  assign results.byte_count     = out_count;
  assign results.error_position = out_pos;

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DROP |=> !results.valid)
    else $error("result produced while dropping after an error");

  a_term_reports: assert property (@(posedge clk) disable iff (rst)
    accept && c == CHAR_NUL && phase != PH_DROP |=>
      results.valid && results.result_kind != KIND_BYTE)
    else $error("terminator did not report done or error");

  a_term_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && c == CHAR_NUL |=>
      phase == PH_IDLE && parsed_count == '0 && char_offset == '0)
    else $error("terminator did not restart the text");

  a_idle_nibble: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HIGH |-> high_nibble == '0)
    else $error("stale high nibble outside a byte");

  a_byte_closes: assert property (@(posedge clk) disable iff (rst)
    accept && has_result && res_kind == KIND_BYTE |=> phase == PH_IDLE)
    else $error("byte completed without returning between bytes");

endmodule

`default_nettype wire
